// File: src/consistent_hash_ring_table_top_assert.svh
// Assertion macros used by the ring table top level.
`ifndef CONSISTENT_HASH_RING_TABLE_TOP_ASSERT_SVH
`define CONSISTENT_HASH_RING_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CHRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/chrt_pkg.sv
// Package with types, codes and widths of the consistent hash ring table.
package chrt_pkg;

  localparam int MaxNodesDef = 64;

  localparam int HashW   = 32;
  localparam int IdW     = 16;
  localparam int ReqW    = 2;
  localparam int StatW   = 2;
  localparam int OidxW   = 6;
  localparam int CntW    = 7;
  localparam int InDataW = 80;
  localparam int OutDataW = 32;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 16;

  typedef enum logic [ReqW-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_SELF_ID      = 1'b0,
    CFG_SELF_ENABLED = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_READ,
    S_EVAL,
    S_FINISH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [HashW-1:0] hash;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

// File: src/consistent_hash_ring_table_top.sv
// Top level of the consistent hash ring table with its request sequencer.
//
//  Channel  | Direction | tdata (low bit up)                          | tuser
//  s_axis   | in        | node_hash, node_id, key_hash                | req_type
//  m_axis   | out       | owner_id, owner_index, in_charge, node_count| status
//  cfg      | in        | index 0 self_id, index 1 self_enabled       | -
//
// One word is worked on at a time; every table read goes through the single
// RAM read port, with a read and an evaluation state per entry touched. Clear,
// an insert into a full table and a lookup on an empty table go straight to
// the result; insert shifts the entries above its slot up, remove and lookup
// walk all entries. Reset clears the state machine, the entry count, the
// configuration and the output valid; the table is not cleared. A stalled
// result holds in the output register while the next word is already worked on.
module consistent_hash_ring_table_top #(
  parameter int MAX_NODES = chrt_pkg::MaxNodesDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // node_hash[31:0], node_id[47:32], key_hash[79:48]
  input  logic [chrt_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [chrt_pkg::ReqW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // owner_id[15:0], owner_index[21:16], in_charge[22], node_count[29:23], zero above
  output logic [chrt_pkg::OutDataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [chrt_pkg::StatW-1:0]    m_axis_tuser,
  input  logic                          cfg_wen,
  input  logic [chrt_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [chrt_pkg::CfgDataW-1:0] cfg_wdata
);

  import chrt_pkg::*;

  `include "consistent_hash_ring_table_top_assert.svh"

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  state_t state, state_next;

  logic [IdW-1:0]   self_id;
  logic             self_enabled;

  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    idx_dec;
  req_t             req;
  logic [HashW-1:0] nhash;
  logic [IdW-1:0]   nid;
  logic [HashW-1:0] key;
  logic             found;

  logic             own_found;
  logic [IdW-1:0]   own_id;
  logic [CW-1:0]    own_pos;
  logic [IdW-1:0]   first_id;
  logic             self_found;
  logic             self_zero;
  logic [HashW-1:0] self_lo;
  logic [HashW-1:0] self_hi;
  logic [HashW-1:0] prev_hash;

  status_t          r_status;
  logic [IdW-1:0]   r_owner_id;
  logic [CW-1:0]    r_owner_pos;
  logic             r_in_charge;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  entry_t           rd;
  entry_t           new_entry;

  logic             in_acc;
  logic             out_load;
  logic             rd_above;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_load  = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign idx_dec   = idx - CW'(1);
  assign rd        = ram_rdata;
  assign new_entry = '{id: nid, hash: nhash};
  assign rd_above  = rd.hash > nhash;

  chrt_ram #(
    .WIDTH (EntryW),
    .DEPTH (MAX_NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        case (req)
          REQ_INSERT: state_next = (count == CW'(MAX_NODES)) ? S_DONE : S_READ;
          REQ_REMOVE: state_next = S_READ;
          REQ_LOOKUP: state_next = (count == '0) ? S_DONE : S_READ;
          default:    state_next = S_DONE;
        endcase
      end
      S_READ: begin
        case (req)
          REQ_INSERT: state_next = (idx == '0) ? S_DONE : S_EVAL;
          REQ_REMOVE: state_next = (idx >= count) ? S_DONE : S_EVAL;
          REQ_LOOKUP: state_next = (idx >= count) ? S_FINISH : S_EVAL;
          default:    state_next = S_DONE;
        endcase
      end
      S_EVAL: begin
        if (req == REQ_INSERT && !rd_above) begin
          state_next = S_DONE;
        end else begin
          state_next = S_READ;
        end
      end
      S_FINISH: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == S_IDLE);
    ram_we        = 1'b0;
    ram_waddr     = idx[AW-1:0];
    ram_wdata     = new_entry;
    ram_raddr     = idx[AW-1:0];
    case (state)
      S_READ: begin
        if (req == REQ_INSERT) begin
          ram_raddr = idx_dec[AW-1:0];
          if (idx == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
          end
        end
      end
      S_EVAL: begin
        case (req)
          REQ_INSERT: begin
            ram_we    = 1'b1;
            ram_wdata = rd_above ? rd : new_entry;
          end
          REQ_REMOVE: begin
            ram_we    = found;
            ram_waddr = idx_dec[AW-1:0];
            ram_wdata = rd;
          end
          default: ram_we = 1'b0;
        endcase
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      self_id       <= '0;
      self_enabled  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wen) begin
        case (cfg_idx)
          CFG_SELF_ID:      self_id <= cfg_wdata[IdW-1:0];
          CFG_SELF_ENABLED: self_enabled <= cfg_wdata[0];
          default:          self_id <= self_id;
        endcase
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_START: begin
          if (req == REQ_CLEAR) begin
            count <= '0;
          end
        end
        S_READ: begin
          if (req == REQ_INSERT && idx == '0) begin
            count <= count + CW'(1);
          end else if (req == REQ_REMOVE && idx >= count && found) begin
            count <= count - CW'(1);
          end
        end
        S_EVAL: begin
          if (req == REQ_INSERT && !rd_above) begin
            count <= count + CW'(1);
          end
        end
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req   <= req_t'(s_axis_tuser);
      nhash <= s_axis_tdata[HashW-1:0];
      nid   <= s_axis_tdata[HashW+IdW-1:HashW];
      key   <= s_axis_tdata[2*HashW+IdW-1:HashW+IdW];
    end

    case (state)
      S_START: begin
        r_status    <= ST_OK;
        r_owner_id  <= '0;
        r_owner_pos <= '0;
        r_in_charge <= 1'b0;
        found       <= 1'b0;
        own_found   <= 1'b0;
        self_found  <= 1'b0;
        idx         <= (req == REQ_INSERT) ? count : '0;
        if (req == REQ_INSERT && count == CW'(MAX_NODES)) begin
          r_status <= ST_FULL;
        end
        if (req == REQ_LOOKUP && count == '0) begin
          r_status <= ST_EMPTY;
        end
      end
      S_READ: begin
        if (req == REQ_REMOVE && idx >= count && !found) begin
          r_status <= ST_NOT_FOUND;
        end
      end
      S_EVAL: begin
        case (req)
          REQ_INSERT: idx <= idx_dec;
          REQ_REMOVE: begin
            if (!found && rd.id == nid) begin
              found <= 1'b1;
            end
            idx <= idx + CW'(1);
          end
          default: begin
            if (!own_found && rd.hash >= key) begin
              own_found <= 1'b1;
              own_id    <= rd.id;
              own_pos   <= idx;
            end
            if (idx == '0) begin
              first_id <= rd.id;
            end
            if (!self_found && rd.id == self_id) begin
              self_found <= 1'b1;
              self_zero  <= (idx == '0);
              self_lo    <= prev_hash;
              self_hi    <= rd.hash;
            end
            prev_hash <= rd.hash;
            idx       <= idx + CW'(1);
          end
        endcase
      end
      S_FINISH: begin
        r_owner_id  <= own_found ? own_id : first_id;
        r_owner_pos <= own_found ? own_pos : '0;
        if (!self_enabled || !self_found) begin
          r_in_charge <= 1'b1;
        end else if (self_zero) begin
          r_in_charge <= (prev_hash < key) || (key <= self_hi);
        end else begin
          r_in_charge <= (self_lo < key) && (key <= self_hi);
        end
      end
      default: idx <= idx;
    endcase

    if (out_load) begin
      m_axis_tuser <= r_status;
      m_axis_tdata <= {{(OutDataW - IdW - OidxW - 1 - CntW){1'b0}}, CntW'(count),
                       r_in_charge, OidxW'(r_owner_pos), r_owner_id};
    end
  end

  `CHRT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(MAX_NODES), "entry count above table size")
  `CHRT_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready, "accepted word while busy")
  `CHRT_ASSERT_NEXT(a_clear_empties, state == S_START && req == REQ_CLEAR,
                    count == '0, "clear left entries")
  `CHRT_ASSERT_NOW(a_remove_write_found, ram_we && req == REQ_REMOVE,
                   found, "remove shifted before match")

endmodule

// File: src/chrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sim/consistent_hash_ring_table_top_tb.sv
// Self-checking testbench for the consistent hash ring table top level.
`timescale 1ns / 100ps

module consistent_hash_ring_table_top_tb;
  import chrt_pkg::*;

  localparam int TableDepth = MaxNodesDef;

  typedef struct packed {
    status_t          status;
    logic [IdW-1:0]   owner_id;
    logic [OidxW-1:0] owner_index;
    logic             in_charge;
    logic [CntW-1:0]  node_count;
  } ring_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // node_hash[31:0], node_id[47:32], key_hash[79:48]
  logic [InDataW-1:0]   s_axis_tdata = '0;
  // req_type[1:0]
  logic [ReqW-1:0]      s_axis_tuser = REQ_CLEAR;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // owner_id[15:0], owner_index[21:16], in_charge[22], node_count[29:23]
  logic [OutDataW-1:0]  m_axis_tdata;
  // status[1:0]
  logic [StatW-1:0]     m_axis_tuser;
  logic                 cfg_wen = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx = CFG_SELF_ID;
  logic [CfgDataW-1:0]  cfg_wdata = '0;

  logic [HashW-1:0] tbl_hash [TableDepth];
  logic [IdW-1:0]   tbl_id [TableDepth];
  int               tbl_count = 0;
  logic [IdW-1:0]   cfg_self_id = '0;
  logic             cfg_self_en = 1'b0;

  ring_result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;
  int words_sent = 0;
  int lookups_sent = 0;
  int full_refusals = 0;
  int results_checked = 0;

  always #5 clk = ~clk;

  consistent_hash_ring_table_top #(
    .MAX_NODES(TableDepth)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_wen(cfg_wen),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  function automatic ring_result_t ring_predict(req_t req, logic [HashW-1:0] nhash,
                                                logic [IdW-1:0] nid, logic [HashW-1:0] key);
    ring_result_t r;
    int pos;
    int s;
    int i;
    r = '0;
    case (req)
      REQ_CLEAR: tbl_count = 0;
      REQ_INSERT: begin
        if (tbl_count >= TableDepth) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_hash[pos] <= nhash) pos++;
          for (i = tbl_count; i > pos; i--) begin
            tbl_hash[i] = tbl_hash[i-1];
            tbl_id[i] = tbl_id[i-1];
          end
          tbl_hash[pos] = nhash;
          tbl_id[pos] = nid;
          tbl_count++;
        end
      end
      REQ_REMOVE: begin
        pos = 0;
        while (pos < tbl_count && tbl_id[pos] != nid) pos++;
        if (pos >= tbl_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          tbl_count--;
          for (i = pos; i < tbl_count; i++) begin
            tbl_hash[i] = tbl_hash[i+1];
            tbl_id[i] = tbl_id[i+1];
          end
        end
      end
      default: begin
        if (tbl_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          pos = 0;
          while (pos < tbl_count && tbl_hash[pos] < key) pos++;
          if (pos >= tbl_count) pos = 0;
          r.owner_id = tbl_id[pos];
          r.owner_index = pos[OidxW-1:0];
          s = 0;
          while (s < tbl_count && tbl_id[s] != cfg_self_id) s++;
          if (!cfg_self_en || s >= tbl_count)
            r.in_charge = 1'b1;
          else if (s > 0)
            r.in_charge = (tbl_hash[s-1] < key) && (key <= tbl_hash[s]);
          else
            r.in_charge = (tbl_hash[tbl_count-1] < key) || (key <= tbl_hash[0]);
        end
      end
    endcase
    r.node_count = tbl_count[CntW-1:0];
    return r;
  endfunction

  function automatic logic [HashW-1:0] pick_hash();
    int r;
    r = $urandom_range(99);
    if (r < 25) return $urandom_range(15);
    if (r < 30) return '0;
    if (r < 35) return '1;
    return $urandom;
  endfunction

  function automatic logic [HashW-1:0] pick_key();
    int r;
    logic [HashW-1:0] k;
    r = $urandom_range(99);
    if (r < 45 && tbl_count > 0) begin
      k = tbl_hash[$urandom_range(tbl_count - 1)];
      case ($urandom_range(2))
        0: k = k - 1;
        1: k = k + 1;
        default: ;
      endcase
      return k;
    end
    if (r < 55) return ($urandom_range(1) != 0) ? '1 : '0;
    return $urandom;
  endfunction

  function automatic logic [IdW-1:0] pick_id(int known_pct);
    if (tbl_count > 0 && $urandom_range(99) < known_pct)
      return tbl_id[$urandom_range(tbl_count - 1)];
    if ($urandom_range(1) != 0) return IdW'($urandom_range(7));
    return IdW'($urandom);
  endfunction

  task automatic send_word(req_t req, logic [HashW-1:0] nhash, logic [IdW-1:0] nid,
                           logic [HashW-1:0] key);
    ring_result_t exp_r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {key, nid, nhash};
    s_axis_tuser <= req;
    do @(posedge clk); while (!s_axis_tready);
    exp_r = ring_predict(req, nhash, nid, key);
    expected_results.push_back(exp_r);
    words_sent++;
    if (req == REQ_LOOKUP) lookups_sent++;
    if (exp_r.status == ST_FULL) full_refusals++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    if (idx == CFG_SELF_ID) cfg_self_id = value;
    else cfg_self_en = value[0];
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_self(logic [IdW-1:0] sid, logic sen);
    write_reg(CFG_SELF_ID, sid);
    write_reg(CFG_SELF_ENABLED, {{(CfgDataW-1){1'b0}}, sen});
  endtask

  task automatic check_word();
    ring_result_t got;
    ring_result_t exp_r;
    got.status = status_t'(m_axis_tuser);
    got.owner_id = m_axis_tdata[15:0];
    got.owner_index = m_axis_tdata[21:16];
    got.in_charge = m_axis_tdata[22];
    got.node_count = m_axis_tdata[29:23];
    results_checked++;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected result word status %0d owner %h", $realtime,
                 got.status, got.owner_id);
    end else begin
      exp_r = expected_results.pop_front();
      if (got.status !== exp_r.status || got.owner_id !== exp_r.owner_id ||
          got.owner_index !== exp_r.owner_index || got.in_charge !== exp_r.in_charge ||
          got.node_count !== exp_r.node_count) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch, expected st %0d id %h idx %0d chg %0d cnt %0d",
                   $realtime, exp_r.status, exp_r.owner_id, exp_r.owner_index,
                   exp_r.in_charge, exp_r.node_count);
          $display("%0t:           got st %0d id %h idx %0d chg %0d cnt %0d",
                   $realtime, got.status, got.owner_id, got.owner_index,
                   got.in_charge, got.node_count);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_word();
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_empty_table();
    send_word(REQ_LOOKUP, '0, '0, '0);
    send_word(REQ_REMOVE, '0, 16'd5, '0);
    send_word(REQ_CLEAR, '1, '1, '1);
  endtask

  task automatic test_order_and_lookup();
    send_word(REQ_INSERT, 32'h8000_0000, 16'h0001, '0);
    send_word(REQ_INSERT, 32'h0000_0000, 16'hFFFF, '0);
    send_word(REQ_INSERT, 32'hFFFF_FFFF, 16'h0000, '0);
    send_word(REQ_INSERT, 32'h8000_0000, 16'h0002, '0);
    send_word(REQ_INSERT, 32'h8000_0000, 16'h0001, '0);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0000);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0001);
    send_word(REQ_LOOKUP, '0, '0, 32'h8000_0000);
    send_word(REQ_LOOKUP, '0, '0, 32'h8000_0001);
    send_word(REQ_LOOKUP, '0, '0, 32'hFFFF_FFFF);
    send_word(REQ_REMOVE, '0, 16'h0000, '0);
    send_word(REQ_LOOKUP, '0, '0, 32'h8000_0001);
  endtask

  task automatic test_self_ownership();
    set_self(16'h0001, 1'b1);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0000);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0001);
    send_word(REQ_LOOKUP, '0, '0, 32'h8000_0001);
    set_self(16'hFFFF, 1'b1);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0000);
    send_word(REQ_LOOKUP, '0, '0, 32'h8000_0001);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0005);
    send_word(REQ_REMOVE, '0, 16'h0001, '0);
    send_word(REQ_LOOKUP, '0, '0, 32'h8000_0000);
    set_self(16'd77, 1'b1);
    send_word(REQ_LOOKUP, '0, '0, 32'h0000_0009);
    send_word(REQ_CLEAR, '0, '0, '0);
  endtask

  task automatic test_full_table();
    send_word(REQ_CLEAR, $urandom, IdW'($urandom), $urandom);
    while (tbl_count < TableDepth)
      send_word(REQ_INSERT, ($urandom_range(3) == 0) ? pick_hash() : $urandom,
                pick_id(20), $urandom);
    repeat (3) send_word(REQ_INSERT, pick_hash(), pick_id(50), $urandom);
    set_self(tbl_id[TableDepth-1], 1'b1);
    repeat (20) send_word(REQ_LOOKUP, $urandom, IdW'($urandom), pick_key());
    repeat (12) send_word(REQ_REMOVE, $urandom, pick_id(70), $urandom);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int count,
                                     logic [IdW-1:0] sid, logic sen);
    int roll;
    set_self(sid, sen);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 3)
        send_word(REQ_CLEAR, $urandom, IdW'($urandom), $urandom);
      else if (roll < 40)
        send_word(REQ_INSERT, pick_hash(), pick_id(30), $urandom);
      else if (roll < 60)
        send_word(REQ_REMOVE, $urandom, pick_id(75), $urandom);
      else
        send_word(REQ_LOOKUP, $urandom, IdW'($urandom), pick_key());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_order_and_lookup();
    test_self_ownership();
    test_full_table();
    test_random_traffic(0, 0, 80, 16'hFFFF, 1'b0);
    test_random_traffic(48, 0, 80, 16'h0000, 1'b1);
    test_random_traffic(0, 48, 80, pick_id(100), 1'b1);
    test_random_traffic(14, 14, 80, 16'hFFFF, 1'b1);
    wait_idle();
    repeat (150) @(posedge clk);
    $display("Sent %0d requests (%0d lookups, %0d refused on a full table), checked %0d results.",
             words_sent, lookups_sent, full_refusals, results_checked);
    $display("Self ownership was tried at both identifier extremes, enabled and disabled.");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, expected_results.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", expected_results.size());
    $display("FAIL");
    $finish;
  end

endmodule

// File: consistent_hash_ring_table_top.f
+incdir+src
src/chrt_pkg.sv
src/chrt_ram.sv
src/consistent_hash_ring_table_top.sv
sim/consistent_hash_ring_table_top_tb.sv
